// File: src/gffnc_pkg.sv
package gffnc_pkg;

    // Default sizes of the graph stores
    localparam int unsigned NODE_CAP_DEF = 1024;
    localparam int unsigned EDGE_CAP_DEF = 8192;

    // Field widths of one request, one result and the node count setting
    localparam int unsigned W_ADDR  = 13;
    localparam int unsigned W_VALUE = 14;
    localparam int unsigned W_NODE  = 10;
    localparam int unsigned W_COLOR = 11;
    localparam int unsigned W_COUNT = 11;

    // Request queue between front and back; depth must stay a power of two
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned QAW     = $clog2(Q_DEPTH);
    localparam int unsigned QCW     = $clog2(Q_DEPTH + 1);

    // Forbidden-colour marks: one word of bits per group of colours, tagged
    localparam int unsigned MARK_BITS  = 32;
    localparam int unsigned MARK_SHIFT = 5;
    localparam int unsigned EPOCH_W    = 8;

    typedef enum logic [1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_NBR = 2'd1,
        OP_COLOR    = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [W_ADDR-1:0]  address;
        logic [W_VALUE-1:0] entry_value;
        logic [W_NODE-1:0]  node;
        logic [W_COLOR-1:0] start_color;
    } t_in_item;

    typedef struct packed {
        logic [W_COLOR-1:0] assigned_color;
        logic               found;
    } t_out_item;

    // Work kinds that the front hands to the back
    typedef enum logic [2:0] {
        K_ROW    = 3'd0,
        K_NBR    = 3'd1,
        K_COLOR  = 3'd2,
        K_REJECT = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_cmd;

    // Queue head as seen by the back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// File: src/gffnc_front.sv
module gffnc_front
    import gffnc_pkg::*;
#(
    parameter int unsigned NODE_CAP = NODE_CAP_DEF,
    parameter int unsigned EDGE_CAP = EDGE_CAP_DEF
) (
    input  logic                          i_start,
    output logic                          o_busy,
    input  t_in_item                      i_item,
    input  logic [$clog2(NODE_CAP+1)-1:0] i_node_count,
    input  logic                          i_q_full,
    input  logic                          i_init,
    output logic                          o_push,
    output t_cmd                          o_cmd
);

    logic [31:0] addr32;
    logic [31:0] node32;
    logic [31:0] nc32;
    logic        keep;
    logic        accept;

    assign addr32 = 32'(i_item.address);
    assign node32 = 32'(i_item.node);
    assign nc32   = 32'(i_node_count);

    // Hold requests off while the queue is full or the stores are being cleared after reset
    assign o_busy = i_q_full | i_init;
    assign accept = i_start & ~o_busy;

    // Classify the request; drop loads that fall outside the stores
    always_comb begin
        keep        = 1'b1;
        o_cmd.item  = i_item;
        o_cmd.kind  = K_CLEAR;
        unique case (i_item.operation)
            OP_LOAD_ROW: begin
                o_cmd.kind = K_ROW;
                keep       = (addr32 <= NODE_CAP);
            end
            OP_LOAD_NBR: begin
                o_cmd.kind = K_NBR;
                keep       = (addr32 < EDGE_CAP);
            end
            OP_COLOR: begin
                o_cmd.kind = (node32 < nc32) ? K_COLOR : K_REJECT;
            end
            OP_CLEAR: begin
                o_cmd.kind = K_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = accept & keep;

endmodule

// File: src/gffnc_queue.sv
module gffnc_queue
    import gffnc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_q_head o_head,
    output logic    o_full
);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] n_wr;
    logic [QAW-1:0] n_rd;
    logic [QCW-1:0] n_cnt;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push & (r_cnt != QCW'(Q_DEPTH));
    assign do_pop  = i_pop & (r_cnt != '0);

    // Advance pointers and fill count
    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign o_full       = (r_cnt == QCW'(Q_DEPTH));

endmodule

// File: src/gffnc_back.sv
module gffnc_back
    import gffnc_pkg::*;
#(
    parameter int unsigned NODE_CAP = NODE_CAP_DEF,
    parameter int unsigned EDGE_CAP = EDGE_CAP_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(NODE_CAP+1)-1:0] i_node_count,
    input  t_q_head                       i_head,
    output logic                          o_pop,
    output logic                          o_init,
    output logic                          o_done,
    output t_out_item                     o_result
);

    localparam int unsigned NW  = $clog2(NODE_CAP);
    localparam int unsigned RAW = $clog2(NODE_CAP + 1);
    localparam int unsigned EW  = $clog2(EDGE_CAP);
    localparam int unsigned ECW = $clog2(EDGE_CAP + 1);
    localparam int unsigned MW  = (NODE_CAP + MARK_BITS - 1) / MARK_BITS;
    localparam int unsigned MWA = (MW > 1) ? $clog2(MW) : 1;
    localparam int unsigned MKW = EPOCH_W + MARK_BITS;

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_CLEAR   = 11'b000_0000_0100,
        S_LO      = 11'b000_0000_1000,
        S_HI      = 11'b000_0001_0000,
        S_NBR     = 11'b000_0010_0000,
        S_COL     = 11'b000_0100_0000,
        S_MARK    = 11'b000_1000_0000,
        S_SCAN_GO = 11'b001_0000_0000,
        S_SCAN    = 11'b010_0000_0000,
        S_WIPE    = 11'b100_0000_0000
    } t_state;

    // Stores
    logic [W_VALUE-1:0] r_rs_mem   [NODE_CAP+1];
    logic [W_VALUE-1:0] r_nb_mem   [EDGE_CAP];
    logic [NW:0]        r_col_mem  [NODE_CAP];
    logic [MKW-1:0]     r_mark_mem [MW];

    logic [W_VALUE-1:0] r_rs_q;
    logic [W_VALUE-1:0] r_nb_q;
    logic [NW:0]        r_col_q;
    logic [MKW-1:0]     r_mark_q;

    // Control and work registers
    t_state             r_state,  n_state;
    logic [NW-1:0]      r_cnt,    n_cnt;
    logic [EPOCH_W-1:0] r_epoch,  n_epoch;
    logic [NW-1:0]      r_node,   n_node;
    logic [W_COLOR-1:0] r_sc,     n_sc;
    logic [W_VALUE-1:0] r_lo,     n_lo;
    logic [EW-1:0]      r_edge,   n_edge;
    logic [ECW-1:0]     r_end,    n_end;
    logic [MWA-1:0]     r_word,   n_word;
    logic [MARK_SHIFT-1:0] r_bit, n_bit;
    logic               r_done,   n_done;
    t_out_item          r_result, n_result;

    // Store ports
    logic               rs_we, rs_re;
    logic [RAW-1:0]     rs_waddr, rs_raddr;
    logic               nb_we, nb_re;
    logic [EW-1:0]      nb_waddr, nb_raddr;
    logic               col_we, col_re;
    logic [NW-1:0]      col_waddr, col_raddr;
    logic [NW:0]        col_wdata;
    logic               mk_we, mk_re;
    logic [MWA-1:0]     mk_waddr, mk_raddr;
    logic [MKW-1:0]     mk_wdata;

    // Helpers
    logic [31:0]           nc32, sc32, cnt32, addr32, hnode32, node1_32;
    logic [31:0]           lo32, hi32, adj32, cval32, edge_nx32;
    logic [31:0]           base32, next_base32, lim32, color32;
    logic [MARK_BITS-1:0]  mk_bits, lo_mask, hi_mask, cand;
    logic                  hit;
    logic [MARK_SHIFT-1:0] hit_idx;
    logic                  more_edges;
    logic [EPOCH_W-1:0]    epoch_nx;

    assign nc32      = 32'(i_node_count);
    assign sc32      = 32'(r_sc);
    assign cnt32     = 32'(r_cnt);
    assign addr32    = 32'(i_head.cmd.item.address);
    assign hnode32   = 32'(i_head.cmd.item.node);
    assign node1_32  = 32'(r_node) + 32'd1;
    assign lo32      = 32'(r_lo);
    assign hi32      = (32'(r_rs_q) > EDGE_CAP) ? 32'(EDGE_CAP) : 32'(r_rs_q);
    assign adj32     = 32'(r_nb_q);
    assign cval32    = 32'(r_col_q[NW-1:0]);
    assign edge_nx32 = 32'(r_edge) + 32'd1;
    assign more_edges = (edge_nx32 < 32'(r_end));
    assign epoch_nx  = r_epoch + 1'b1;

    // Marks of a word whose tag is stale read as clear
    assign mk_bits = (r_mark_q[MARK_BITS +: EPOCH_W] == r_epoch) ?
                     r_mark_q[MARK_BITS-1:0] : '0;

    // Window of colours in the current word: at or above start, below the count
    assign base32      = 32'(r_word) << MARK_SHIFT;
    assign next_base32 = base32 + MARK_BITS;
    assign lim32       = nc32 - base32;
    assign lo_mask = (32'(r_word) == (sc32 >> MARK_SHIFT)) ?
                     ~((MARK_BITS'(1) << sc32[MARK_SHIFT-1:0]) - MARK_BITS'(1)) : '1;
    assign hi_mask = (lim32 >= MARK_BITS) ? '1 :
                     ((MARK_BITS'(1) << lim32[MARK_SHIFT-1:0]) - MARK_BITS'(1));
    assign cand    = ~mk_bits & lo_mask & hi_mask;

    // Pick the lowest free colour of the word
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MARK_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit     = 1'b1;
                hit_idx = MARK_SHIFT'(i);
            end
        end
    end

    assign color32 = base32 | 32'(hit_idx);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_epoch  = r_epoch;
        n_node   = r_node;
        n_sc     = r_sc;
        n_lo     = r_lo;
        n_edge   = r_edge;
        n_end    = r_end;
        n_word   = r_word;
        n_bit    = r_bit;
        n_done   = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;

        rs_we     = 1'b0;
        rs_waddr  = addr32[RAW-1:0];
        rs_re     = 1'b0;
        rs_raddr  = hnode32[RAW-1:0];
        nb_we     = 1'b0;
        nb_waddr  = addr32[EW-1:0];
        nb_re     = 1'b0;
        nb_raddr  = lo32[EW-1:0];
        col_we    = 1'b0;
        col_waddr = r_cnt;
        col_wdata = '0;
        col_re    = 1'b0;
        col_raddr = adj32[NW-1:0];
        mk_we     = 1'b0;
        mk_waddr  = cnt32[MWA-1:0];
        mk_wdata  = '0;
        mk_re     = 1'b0;
        mk_raddr  = sc32[MARK_SHIFT +: MWA];

        unique case (r_state)
            S_INIT: begin
                // Clear colour flags and mark tags after reset
                col_we = 1'b1;
                mk_we  = (cnt32 < MW);
                n_cnt  = r_cnt + 1'b1;
                if (cnt32 == NODE_CAP - 1) begin
                    n_epoch = EPOCH_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.kind)
                        K_ROW: begin
                            rs_we = 1'b1;
                        end
                        K_NBR: begin
                            nb_we = 1'b1;
                        end
                        K_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        K_REJECT: begin
                            n_done   = 1'b1;
                            n_result = '{assigned_color: nc32[W_COLOR-1:0], found: 1'b0};
                        end
                        K_COLOR: begin
                            rs_re   = 1'b1;
                            n_node  = hnode32[NW-1:0];
                            n_sc    = i_head.cmd.item.start_color;
                            n_state = S_LO;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                // Mark every node uncoloured
                col_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (cnt32 == NODE_CAP - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_LO: begin
                // Row start arrives; fetch the next row start
                n_lo     = r_rs_q;
                rs_re    = 1'b1;
                rs_raddr = node1_32[RAW-1:0];
                n_state  = S_HI;
            end
            S_HI: begin
                n_end = hi32[ECW-1:0];
                if (lo32 < hi32) begin
                    nb_re   = 1'b1;
                    n_edge  = lo32[EW-1:0];
                    n_state = S_NBR;
                end else begin
                    n_state = S_SCAN_GO;
                end
            end
            S_NBR: begin
                // Skip neighbours outside the graph
                if (adj32 < nc32) begin
                    col_re  = 1'b1;
                    n_state = S_COL;
                end else if (more_edges) begin
                    nb_re    = 1'b1;
                    nb_raddr = edge_nx32[EW-1:0];
                    n_edge   = edge_nx32[EW-1:0];
                end else begin
                    n_state = S_SCAN_GO;
                end
            end
            S_COL: begin
                // Only coloured neighbours with a colour below the count forbid
                if (r_col_q[NW] && (cval32 < nc32)) begin
                    mk_re    = 1'b1;
                    mk_raddr = cval32[MARK_SHIFT +: MWA];
                    n_word   = cval32[MARK_SHIFT +: MWA];
                    n_bit    = cval32[MARK_SHIFT-1:0];
                    n_state  = S_MARK;
                end else if (more_edges) begin
                    nb_re    = 1'b1;
                    nb_raddr = edge_nx32[EW-1:0];
                    n_edge   = edge_nx32[EW-1:0];
                    n_state  = S_NBR;
                end else begin
                    n_state = S_SCAN_GO;
                end
            end
            S_MARK: begin
                // Set the forbidden bit and retag the word
                mk_we    = 1'b1;
                mk_waddr = r_word;
                mk_wdata = {r_epoch, mk_bits | (MARK_BITS'(1) << r_bit)};
                if (more_edges) begin
                    nb_re    = 1'b1;
                    nb_raddr = edge_nx32[EW-1:0];
                    n_edge   = edge_nx32[EW-1:0];
                    n_state  = S_NBR;
                end else begin
                    n_state = S_SCAN_GO;
                end
            end
            S_SCAN_GO: begin
                if (sc32 < nc32) begin
                    mk_re   = 1'b1;
                    n_word  = sc32[MARK_SHIFT +: MWA];
                    n_state = S_SCAN;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{assigned_color: nc32[W_COLOR-1:0], found: 1'b0};
                    n_epoch  = epoch_nx;
                    n_cnt    = '0;
                    n_state  = (epoch_nx == '0) ? S_WIPE : S_IDLE;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    col_we    = 1'b1;
                    col_waddr = r_node;
                    col_wdata = {1'b1, color32[NW-1:0]};
                    n_done    = 1'b1;
                    n_result  = '{assigned_color: color32[W_COLOR-1:0], found: 1'b1};
                    n_epoch   = epoch_nx;
                    n_cnt     = '0;
                    n_state   = (epoch_nx == '0) ? S_WIPE : S_IDLE;
                end else if (next_base32 < nc32) begin
                    mk_re    = 1'b1;
                    mk_raddr = next_base32[MARK_SHIFT +: MWA];
                    n_word   = next_base32[MARK_SHIFT +: MWA];
                end else begin
                    n_done   = 1'b1;
                    n_result = '{assigned_color: nc32[W_COLOR-1:0], found: 1'b0};
                    n_epoch  = epoch_nx;
                    n_cnt    = '0;
                    n_state  = (epoch_nx == '0) ? S_WIPE : S_IDLE;
                end
            end
            S_WIPE: begin
                // Epoch wrapped: drop every tag before reuse
                mk_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (cnt32 == MW - 1) begin
                    n_epoch = EPOCH_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_epoch <= EPOCH_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_epoch <= n_epoch;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_sc     <= n_sc;
        r_lo     <= n_lo;
        r_edge   <= n_edge;
        r_end    <= n_end;
        r_word   <= n_word;
        r_bit    <= n_bit;
        r_result <= n_result;
    end

    // Row start store
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rs_mem[rs_waddr] <= i_head.cmd.item.entry_value;
        end
        if (rs_re) begin
            r_rs_q <= r_rs_mem[rs_raddr];
        end
    end

    // Neighbour store
    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            r_nb_mem[nb_waddr] <= i_head.cmd.item.entry_value;
        end
        if (nb_re) begin
            r_nb_q <= r_nb_mem[nb_raddr];
        end
    end

    // Node colour store: colour flag over colour value
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[col_waddr] <= col_wdata;
        end
        if (col_re) begin
            r_col_q <= r_col_mem[col_raddr];
        end
    end

    // Forbidden mark store: epoch tag over mark bits
    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            r_mark_mem[mk_waddr] <= mk_wdata;
        end
        if (mk_re) begin
            r_mark_q <= r_mark_mem[mk_raddr];
        end
    end

    assign o_init   = (r_state == S_INIT);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: src/greedy_first_fit_node_coloring_core.sv
// Channel   Direction  Handshake                       Payload
// request   in         start high, busy low            i_cmd (t_in_item)
// result    out        o_done strobe, one cycle        o_result (t_out_item)
// config    in         i_cfg_valid and o_cfg_ready     i_cfg_data (node count)
//
// Loads and rejected colour requests are done as they leave the queue; a clear
// sweeps the colour store over all NODE_CAP entries.
// A colour request reads its two row starts, then each neighbour and the colour of
// each in-range one, marking those coloured; then it scans the 32-colour mark words.
// Every 255th colour request that is not rejected adds a wipe of the mark tags.
// After reset busy stays high while the stores are cleared.
// A four-deep request queue decouples intake from the sequencer; the receiver
// cannot stall, so each result is shown for exactly one cycle.
module greedy_first_fit_node_coloring_core
    import gffnc_pkg::*;
#(
    parameter int unsigned NODE_CAP = NODE_CAP_DEF,
    parameter int unsigned EDGE_CAP = EDGE_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_cmd,
    output logic               o_done,
    output t_out_item          o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [W_COUNT-1:0] i_cfg_data
);

    localparam int unsigned NCW = $clog2(NODE_CAP + 1);

    logic [NCW-1:0] r_node_count;
    logic [NCW-1:0] n_node_count;
    logic [31:0]    cfg32;
    logic           q_full;
    logic           init;
    logic           push;
    logic           pop;
    t_cmd           push_cmd;
    t_q_head        head;

    // Clamp the written count into one to NODE_CAP
    assign cfg32       = 32'(i_cfg_data);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_node_count = r_node_count;
        if (i_cfg_valid) begin
            if (cfg32 == 32'd0) begin
                n_node_count = NCW'(1);
            end else if (cfg32 > NODE_CAP) begin
                n_node_count = NCW'(NODE_CAP);
            end else begin
                n_node_count = cfg32[NCW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NCW'(NODE_CAP);
        end else begin
            r_node_count <= n_node_count;
        end
    end

    gffnc_front #(
        .NODE_CAP (NODE_CAP),
        .EDGE_CAP (EDGE_CAP)
    ) u_front (
        .i_start      (start),
        .o_busy       (busy),
        .i_item       (i_cmd),
        .i_node_count (r_node_count),
        .i_q_full     (q_full),
        .i_init       (init),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    gffnc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    gffnc_back #(
        .NODE_CAP (NODE_CAP),
        .EDGE_CAP (EDGE_CAP)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_head       (head),
        .o_pop        (pop),
        .o_init       (init),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule

// File: src/gffnc_checker.sv
module gffnc_checker
    import gffnc_pkg::*;
#(
    parameter int unsigned NODE_CAP = NODE_CAP_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input t_in_item           i_cmd,
    input logic               i_done,
    input t_out_item          i_result,
    input logic               i_cfg_valid,
    input logic               i_cfg_ready,
    input logic [W_COUNT-1:0] i_cfg_data
);

    logic [31:0] r_nc;
    logic [31:0] n_nc;
    logic [3:0]  r_pending;
    logic [3:0]  n_pending;
    logic [31:0] cfg32;
    logic [31:0] color32;
    logic        color_req;

    assign cfg32     = 32'(i_cfg_data);
    assign color32   = 32'(i_result.assigned_color);
    assign color_req = i_start && !i_busy && (i_cmd.operation == OP_COLOR);

    // Track the clamped node count and the colour requests still owed a result
    always_comb begin
        n_nc = r_nc;
        if (i_cfg_valid && i_cfg_ready) begin
            if (cfg32 == 32'd0) begin
                n_nc = 32'd1;
            end else if (cfg32 > NODE_CAP) begin
                n_nc = NODE_CAP;
            end else begin
                n_nc = cfg32;
            end
        end
        n_pending = r_pending + 4'(color_req) - 4'(i_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc      <= NODE_CAP;
            r_pending <= '0;
        end else begin
            r_nc      <= n_nc;
            r_pending <= n_pending;
        end
    end

    a_result_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (r_pending != 4'd0))
        else $error("result without an outstanding colour request");

    a_miss_reports_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && !i_result.found) |-> (color32 == (r_nc & 32'h7FF)))
        else $error("missed colour does not report the node count");

    a_hit_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_result.found) |-> (color32 < r_nc))
        else $error("assigned colour not below the node count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_busy && !i_done))
        else $error("block not busy and quiet after reset");

endmodule

bind greedy_first_fit_node_coloring_core gffnc_checker #(
    .NODE_CAP (NODE_CAP)
) u_gffnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (start),
    .i_busy      (busy),
    .i_cmd       (i_cmd),
    .i_done      (o_done),
    .i_result    (o_result),
    .i_cfg_valid (i_cfg_valid),
    .i_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gffnc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 200000;
    // Four queued clears behind an active one, plus margin
    localparam int unsigned SETTLE_CYCLES  = 6000;
    localparam int unsigned PHASE_ITEMS    = 150;
    localparam int unsigned PHASES         = 10;

    // Predictor of the colouring block plus the store of expected colour results
    class coloring_scoreboard;
        logic [W_VALUE-1:0] row_start [0:NODE_CAP_DEF];
        bit                 row_set   [0:NODE_CAP_DEF];
        logic [W_VALUE-1:0] nbr_entry [0:EDGE_CAP_DEF-1];
        bit                 nbr_set   [0:EDGE_CAP_DEF-1];
        logic [W_COLOR-1:0] node_color [0:NODE_CAP_DEF-1];
        bit                 colored    [0:NODE_CAP_DEF-1];
        int unsigned        count = NODE_CAP_DEF;
        t_out_item          expected_colors [$];
        int unsigned        errors = 0;

        function void set_count(logic [W_COUNT-1:0] value);
            count = value;
            if (count == 0) count = 1;
            if (count > NODE_CAP_DEF) count = NODE_CAP_DEF;
        endfunction

        // True when a colour request on this node reads only written table entries
        function bit can_color(int unsigned nd);
            int unsigned lo;
            int unsigned hi;
            if (nd >= count) return 1'b1;
            if (!row_set[nd] || !row_set[nd+1]) return 1'b0;
            lo = row_start[nd];
            hi = row_start[nd+1];
            if (hi > EDGE_CAP_DEF) hi = EDGE_CAP_DEF;
            for (int unsigned e = lo; e < hi; e++)
                if (!nbr_set[e]) return 1'b0;
            return 1'b1;
        endfunction

        // First-fit colour search; updates the stored colour when one fits
        function t_out_item predict_color(int unsigned nd, int unsigned first_color);
            t_out_item            r;
            int unsigned          lo;
            int unsigned          hi;
            int unsigned          adj;
            bit [NODE_CAP_DEF-1:0] taken;
            r.assigned_color = W_COLOR'(count);
            r.found          = 1'b0;
            if (nd >= count) return r;
            taken = '0;
            lo = row_start[nd];
            hi = row_start[nd+1];
            if (hi > EDGE_CAP_DEF) hi = EDGE_CAP_DEF;
            // mark colours held by coloured neighbours
            for (int unsigned e = lo; e < hi; e++) begin
                adj = nbr_entry[e];
                if (adj < count && colored[adj] && node_color[adj] < count)
                    taken[node_color[adj]] = 1'b1;
            end
            for (int unsigned c = first_color; c < count; c++) begin
                if (!taken[c]) begin
                    node_color[nd]   = W_COLOR'(c);
                    colored[nd]      = 1'b1;
                    r.assigned_color = W_COLOR'(c);
                    r.found          = 1'b1;
                    return r;
                end
            end
            return r;
        endfunction

        function void note_request(t_in_item it);
            case (it.operation)
                OP_LOAD_ROW: begin
                    if (it.address <= NODE_CAP_DEF) begin
                        row_start[it.address] = it.entry_value;
                        row_set[it.address]   = 1'b1;
                    end
                end
                OP_LOAD_NBR: begin
                    if (it.address < EDGE_CAP_DEF) begin
                        nbr_entry[it.address] = it.entry_value;
                        nbr_set[it.address]   = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    foreach (colored[i]) colored[i] = 1'b0;
                end
                default: begin
                    expected_colors = {expected_colors,
                                       predict_color(it.node, it.start_color)};
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_colors.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got colour %0d found %0b",
                         $time, got.assigned_color, got.found);
                errors++;
                return;
            end
            want = expected_colors.pop_front();
            if (got.assigned_color !== want.assigned_color) begin
                $display("%0t ns: assigned_color expected %0d, got %0d",
                         $time, want.assigned_color, got.assigned_color);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t ns: found expected %0b, got %0b", $time, want.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_item            i_cmd;
    logic                o_done;
    t_out_item           o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [W_COUNT-1:0]  i_cfg_data;

    coloring_scoreboard  board;
    int unsigned         idle_pct = 0;
    int unsigned         sent = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         count_steps [PHASES];
    int unsigned         idle_steps [4];

    greedy_first_fit_node_coloring_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Check each result strobe against the oldest expected colour
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_result);
    end

    // Stop the run when no handshake of any kind happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_op op, int unsigned addr, int unsigned value,
                                           int unsigned nd, int unsigned first_color);
        t_in_item it;
        it.operation   = op;
        it.address     = W_ADDR'(addr);
        it.entry_value = W_VALUE'(value);
        it.node        = W_NODE'(nd);
        it.start_color = W_COLOR'(first_color);
        return it;
    endfunction

    // Present one request, idling first at random, and hold it until taken
    task automatic send_item(input t_in_item it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_cmd <= it;
        do @(posedge i_clk); while (busy);
        board.note_request(it);
        if (!(it.operation == OP_LOAD_ROW && it.address > NODE_CAP_DEF)) sent++;
    endtask

    // Hold off until every colour result is in and trailing work has drained
    task automatic settle_block();
        start <= 1'b0;
        while (board.expected_colors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [W_COUNT-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_count(value);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_start_color();
        int unsigned r;
        r = $urandom_range(15);
        if (r < 10) return 0;
        if (r < 13) return $urandom_range(board.count - 1);
        if (r == 13) return board.count - 1;
        if (r == 14) return $urandom_range(2047);
        return $urandom_range(2047, board.count);
    endfunction

    // Random request of any kind; slow clears kept rare
    task automatic send_noise();
        t_in_item it;
        it.operation   = t_op'($urandom_range(3));
        it.address     = $urandom_range(1) ? W_ADDR'($urandom_range(1100))
                                           : W_ADDR'($urandom_range(8191));
        it.entry_value = W_VALUE'($urandom_range(16383));
        it.node        = W_NODE'($urandom_range(1023));
        it.start_color = W_COLOR'(pick_start_color());
        if (it.operation == OP_CLEAR && $urandom_range(15) != 0) it.operation = OP_LOAD_NBR;
        if (it.operation == OP_COLOR && !board.can_color(it.node)) return;
        send_item(it);
    endtask

    // Load a small graph in shuffled order, maybe clear, then colour its nodes
    task automatic run_graph_round();
        int unsigned span;
        int unsigned first;
        int unsigned total;
        int unsigned base;
        int unsigned offset;
        int unsigned r;
        int unsigned nd;
        int unsigned j;
        int unsigned value;
        int unsigned degree [$];
        t_in_item    loads [$];
        t_in_item    tmp;
        if (board.count <= 24) begin
            first = 0;
            span  = board.count;
        end else begin
            span  = $urandom_range(24, 3);
            first = ($urandom_range(7) == 0) ? $urandom_range(NODE_CAP_DEF - span)
                                             : $urandom_range(board.count - span);
        end
        total = 0;
        for (int unsigned i = 0; i < span; i++) begin
            degree = {degree,
                      ($urandom_range(15) == 0) ? $urandom_range(32) : $urandom_range(6)};
            total += degree[i];
        end
        base   = $urandom_range(EDGE_CAP_DEF - total);
        offset = base;
        for (int unsigned i = 0; i <= span; i++) begin
            loads = {loads, make_item(OP_LOAD_ROW, first + i, offset, 0, 0)};
            if (i < span) begin
                for (int unsigned d = 0; d < degree[i]; d++) begin
                    r = $urandom_range(9);
                    if (r < 7)       value = first + $urandom_range(span - 1);
                    else if (r == 7) value = first + i;
                    else if (r == 8) value = $urandom_range(16383);
                    else             value = $urandom_range(1023);
                    loads = {loads, make_item(OP_LOAD_NBR, offset + d, value, 0, 0)};
                end
                offset += degree[i];
            end
        end
        for (int i = loads.size() - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = loads[i];
            loads[i] = loads[j];
            loads[j] = tmp;
        end
        foreach (loads[i]) send_item(loads[i]);
        if ($urandom_range(9) < 7) send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        repeat (span + span / 2 + 1) begin
            if ($urandom_range(5) == 0) send_noise();
            nd = first + $urandom_range(span - 1);
            if (board.can_color(nd))
                send_item(make_item(OP_COLOR, 0, 0, nd, pick_start_color()));
        end
    endtask

    // Table edges, self loop, empty and inverted rows, no fit and clear
    task automatic run_directed();
        send_item(make_item(OP_LOAD_ROW, 8191, 5, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 1025, 5, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 1024, 16383, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 1023, 8190, 0, 0));
        send_item(make_item(OP_LOAD_NBR, 8190, 1023, 0, 0));
        send_item(make_item(OP_LOAD_NBR, 8191, 16383, 0, 0));
        send_item(make_item(OP_COLOR, 0, 0, 1023, 0));
        send_item(make_item(OP_COLOR, 0, 0, 1023, 0));
        send_item(make_item(OP_LOAD_ROW, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 1, 2, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 2, 2, 0, 0));
        send_item(make_item(OP_LOAD_ROW, 3, 0, 0, 0));
        send_item(make_item(OP_LOAD_NBR, 0, 1, 0, 0));
        send_item(make_item(OP_LOAD_NBR, 1, 1023, 0, 0));
        send_item(make_item(OP_COLOR, 0, 0, 1, 0));
        send_item(make_item(OP_COLOR, 0, 0, 0, 0));
        send_item(make_item(OP_COLOR, 0, 0, 0, 2047));
        send_item(make_item(OP_COLOR, 0, 0, 1, 1023));
        send_item(make_item(OP_COLOR, 0, 0, 0, 1023));
        send_item(make_item(OP_COLOR, 0, 0, 2, 0));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_COLOR, 0, 0, 0, 0));
        send_item(make_item(OP_COLOR, 0, 0, 1023, 1024));
    endtask

    initial begin
        int unsigned phase_goal;
        board       = new();
        count_steps = '{0, 12, 2047, 1, 37, 1024, 2, 300, 1023, 64};
        idle_steps  = '{0, 76, 0, 23};
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // each phase: drain, set the node count, then random graph rounds
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            write_count(W_COUNT'(count_steps[ph]));
            idle_pct   = idle_steps[ph % 4];
            phase_goal = sent + PHASE_ITEMS;
            while (sent < phase_goal) run_graph_round();
        end
        settle_block();

        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
